FILE: design/nats_pkg.sv
// Shared types, constants and the circular distance function for the
// nearest angle triple search. No dependencies.
`default_nettype none

package nats_pkg;

    localparam int ANGLE_W = 16;
    localparam int CFG_W   = 7;
    localparam int IDX_W   = 6;
    localparam int SQ_W    = 31;
    localparam int DIST2_W = 32;
    localparam int WORD_W  = 3 * ANGLE_W;
    localparam int STEP_W  = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 88;

    // operation codes (s_tuser)
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // per-entry steps of the shared distance/square/accumulate unit
    localparam logic [STEP_W-1:0] STEP_PHI   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PSI   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_OMEGA = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ACC   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CMP   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CALC,
        ST_GRAB,
        ST_OUT
    } state_t;

    // circular distance of two binary angles, 0..32768
    function automatic logic [ANGLE_W-1:0] circ_dist(
        input logic [ANGLE_W-1:0] a,
        input logic [ANGLE_W-1:0] b
    );
        logic [ANGLE_W:0] diff;
        logic [ANGLE_W:0] mag;
        diff = {a[ANGLE_W-1], a} - {b[ANGLE_W-1], b};
        mag  = diff[ANGLE_W] ? (~diff + 17'd1) : diff;
        if (mag > 17'd32768) begin
            mag = 17'd65536 - mag;
        end
        return mag[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/nats_angle_mem.sv
// Angle triple table: one write port, one registered read port.
// Depends on nats_pkg for the word width.
`default_nettype none

module nats_angle_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                           aclk,
    input  wire                           wr_en,
    input  wire  [ADDR_W-1:0]             wr_addr,
    input  wire  [nats_pkg::WORD_W-1:0]   wr_data,
    input  wire  [ADDR_W-1:0]             rd_addr,
    output logic [nats_pkg::WORD_W-1:0]   rd_data
);

    logic [nats_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/nearest_angle_triple_search.sv
// Nearest angle triple search: top level with sequencer and shared distance unit.
// Depends on nats_pkg and nats_angle_mem.
//
// Usage:
//   s_ channel: s_tuser = 0 loads a triple into slot entry_index, s_tuser = 1
//   queries the table for the triple nearest to the given angles.
//   m_ channel: one beat per query, none per load. m_tuser = found.
//   cfg_we / cfg_wdata set entry_count, the number of slots a query scans
//   (saturated to MAX_ENTRIES); write it only while the block is idle.
// Scan sequence:
//   A load is written to the table as its beat is accepted. A query scans
//   entry_count entries through one shared distance / 16x16 square /
//   accumulate unit: each entry passes three angle lanes, then two
//   accumulate/compare steps, with a table read before the scan and a
//   re-read of the winning entry before the result beat is registered.
//   A zero entry_count skips the scan and goes straight to the result.
//   s_tready is high only while no query is in flight.
// Reset clears the sequencer, the output valid and entry_count; the table
// holds garbage until loaded. A stalled m_ beat holds in the output
// register; loads still go through, and a following query finishes its
// scan and waits for the register to free.
`default_nettype none

module nearest_angle_triple_search #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // config
    input  wire                                cfg_we,
    input  wire  [nats_pkg::CFG_W-1:0]         cfg_wdata,   // entry_count
    // input beats
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [5:0] entry_index, [21:6] phi_angle, [37:22] psi_angle,
    // [53:38] omega_angle, [55:54] zero
    input  wire  [nats_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                                s_tuser,     // operation
    // result beats
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [5:0] best_index, [21:6] best_phi, [37:22] best_psi,
    // [53:38] best_omega, [85:54] best_sq_distance, [87:86] zero
    output logic [nats_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser      // found
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW     = nats_pkg::ANGLE_W;
    localparam int CW     = nats_pkg::CFG_W;

    // input field views
    logic [nats_pkg::IDX_W-1:0]  s_entry_index;
    logic [nats_pkg::WORD_W-1:0] s_angles;      // {omega, psi, phi}
    assign s_entry_index = s_tdata[5:0];
    assign s_angles      = s_tdata[53:6];

    // control registers
    nats_pkg::state_t         state_reg,  state_next;
    logic [nats_pkg::STEP_W-1:0] step_reg, step_next;
    logic [CW-1:0]            scan_reg,   scan_next;
    logic                     have_reg,   have_next;
    logic                     m_valid_reg, m_valid_next;
    logic [CW-1:0]            entry_count_reg;

    // datapath registers
    logic [CW-1:0]                count_reg,   count_next;
    logic [nats_pkg::WORD_W-1:0]  q_reg,       q_next;
    logic [ADDR_W-1:0]            addr_reg,    addr_next;
    logic [AW-1:0]                dist_reg,    dist_next;
    logic [nats_pkg::SQ_W-1:0]    sq_reg,      sq_next;
    logic [nats_pkg::DIST2_W-1:0] acc_reg,     acc_next;
    logic [nats_pkg::DIST2_W-1:0] best_d_reg,  best_d_next;
    logic [CW-1:0]                best_idx_reg, best_idx_next;
    logic                         out_found_reg, out_found_next;
    logic [nats_pkg::IDX_W-1:0]   out_idx_reg,   out_idx_next;
    logic [nats_pkg::WORD_W-1:0]  out_ang_reg,   out_ang_next;
    logic [nats_pkg::DIST2_W-1:0] out_dist_reg,  out_dist_next;

    // table
    logic                         mem_we;
    logic [nats_pkg::WORD_W-1:0]  rd_data;

    // shared unit operands
    logic [AW-1:0]                lane_q;
    logic [AW-1:0]                lane_t;
    logic [AW-1:0]                lane_dist;
    logic [31:0]                  prod;
    logic [nats_pkg::DIST2_W-1:0] sum;
    logic [CW-1:0]                scan_inc;
    logic [CW-1:0]                count_sat;
    logic                         in_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign mem_we   = in_beat && (s_tuser == nats_pkg::OP_LOAD)
                   && (32'(s_entry_index) < 32'(MAX_ENTRIES));
    assign scan_inc = scan_reg + 7'd1;
    assign count_sat = (32'(entry_count_reg) > 32'(MAX_ENTRIES))
                     ? CW'(MAX_ENTRIES) : entry_count_reg;

    nats_angle_mem #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (ADDR_W'(s_entry_index)),
        .wr_data (s_angles),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // lane select for the distance unit
    always_comb begin
        case (step_reg)
            nats_pkg::STEP_PHI: begin
                lane_q = q_reg[15:0];
                lane_t = rd_data[15:0];
            end
            nats_pkg::STEP_PSI: begin
                lane_q = q_reg[31:16];
                lane_t = rd_data[31:16];
            end
            default: begin
                lane_q = q_reg[47:32];
                lane_t = rd_data[47:32];
            end
        endcase
    end

    assign lane_dist = nats_pkg::circ_dist(lane_q, lane_t);
    assign prod      = 32'(dist_reg) * 32'(dist_reg);
    assign sum       = acc_reg + 32'(sq_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        scan_next      = scan_reg;
        have_next      = have_reg;
        m_valid_next   = m_valid_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        addr_next      = addr_reg;
        dist_next      = dist_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_ang_next   = out_ang_reg;
        out_dist_next  = out_dist_reg;
        s_tready       = (state_reg == nats_pkg::ST_IDLE);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            nats_pkg::ST_IDLE: begin
                if (s_tvalid && (s_tuser == nats_pkg::OP_QUERY)) begin
                    q_next     = s_angles;
                    count_next = count_sat;
                    scan_next  = '0;
                    have_next  = 1'b0;
                    step_next  = nats_pkg::STEP_PHI;
                    addr_next  = '0;
                    state_next = (count_sat == '0) ? nats_pkg::ST_OUT
                                                   : nats_pkg::ST_FETCH;
                end
            end
            nats_pkg::ST_FETCH: begin
                state_next = nats_pkg::ST_CALC;
            end
            nats_pkg::ST_CALC: begin
                case (step_reg)
                    nats_pkg::STEP_PHI: begin
                        dist_next = lane_dist;
                        step_next = nats_pkg::STEP_PSI;
                    end
                    nats_pkg::STEP_PSI: begin
                        dist_next = lane_dist;
                        sq_next   = prod[30:0];
                        step_next = nats_pkg::STEP_OMEGA;
                    end
                    nats_pkg::STEP_OMEGA: begin
                        dist_next = lane_dist;
                        sq_next   = prod[30:0];
                        acc_next  = 32'(sq_reg);
                        // prefetch next entry while the sum finishes
                        addr_next = ADDR_W'(scan_inc);
                        step_next = nats_pkg::STEP_ACC;
                    end
                    nats_pkg::STEP_ACC: begin
                        sq_next   = prod[30:0];
                        acc_next  = sum;
                        step_next = nats_pkg::STEP_CMP;
                    end
                    nats_pkg::STEP_CMP: begin
                        // first strict minimum wins ties
                        if (!have_reg || (sum < best_d_reg)) begin
                            best_d_next   = sum;
                            best_idx_next = scan_reg;
                            have_next     = 1'b1;
                        end
                        step_next = nats_pkg::STEP_PHI;
                        if (scan_inc == count_reg) begin
                            addr_next  = ADDR_W'(best_idx_next);
                            state_next = nats_pkg::ST_GRAB;
                        end else begin
                            scan_next = scan_inc;
                        end
                    end
                    default: begin
                        step_next = nats_pkg::STEP_PHI;
                    end
                endcase
            end
            nats_pkg::ST_GRAB: begin
                state_next = nats_pkg::ST_OUT;
            end
            nats_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_found_next = have_reg;
                    out_idx_next   = have_reg ? best_idx_reg[5:0] : '0;
                    out_ang_next   = have_reg ? rd_data : '0;
                    out_dist_next  = have_reg ? best_d_reg : '0;
                    m_valid_next   = 1'b1;
                    state_next     = nats_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= nats_pkg::ST_IDLE;
            step_reg        <= nats_pkg::STEP_PHI;
            scan_reg        <= '0;
            have_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            entry_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            scan_reg    <= scan_next;
            have_reg    <= have_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg     <= count_next;
        q_reg         <= q_next;
        addr_reg      <= addr_next;
        dist_reg      <= dist_next;
        sq_reg        <= sq_next;
        acc_reg       <= acc_next;
        best_d_reg    <= best_d_next;
        best_idx_reg  <= best_idx_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_ang_reg   <= out_ang_next;
        out_dist_reg  <= out_dist_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {2'b00, out_dist_reg, out_ang_reg, out_idx_reg};

endmodule

`default_nettype wire

FILE: test/nats_checker.sv
// Scoreboard for nearest_angle_triple_search: mirrors the angle table and
// entry_count from the observed beats, predicts each query result and checks it.
// Depends on nats_pkg.

module nats_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [nats_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire  [nats_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                              s_tuser,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    input  wire  [nats_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire                              m_tuser,
    output int                               mismatch_count,
    output int                               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import nats_pkg::*;

    // field offsets, shared by both channels
    localparam int PHI_LSB   = IDX_W;
    localparam int PSI_LSB   = IDX_W + ANGLE_W;
    localparam int OMEGA_LSB = IDX_W + 2 * ANGLE_W;
    localparam int DIST_LSB  = IDX_W + 3 * ANGLE_W;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   index;
        logic [ANGLE_W-1:0] phi;
        logic [ANGLE_W-1:0] psi;
        logic [ANGLE_W-1:0] omega;
        logic [DIST2_W-1:0] sq_dist;
    } match_t;

    logic [ANGLE_W-1:0] phi_mem   [TABLE_DEPTH];
    logic [ANGLE_W-1:0] psi_mem   [TABLE_DEPTH];
    logic [ANGLE_W-1:0] omega_mem [TABLE_DEPTH];
    logic [CFG_W-1:0]   scan_count;
    match_t             match_q [$];
    int                 errs = 0;

    // shortest way round the circle, 0..32768
    function automatic int unsigned arc_gap(logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] b);
        int d;
        d = int'($signed(a)) - int'($signed(b));
        if (d < 0) d = -d;
        if (d > 32768) d = 65536 - d;
        return d;
    endfunction

    function automatic match_t nearest_entry(logic [ANGLE_W-1:0] qphi,
                                             logic [ANGLE_W-1:0] qpsi,
                                             logic [ANGLE_W-1:0] qomega);
        match_t             best;
        int unsigned        limit;
        int unsigned        dp, ds, dw;
        logic [DIST2_W-1:0] sum;
        best  = '0;
        limit = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
        for (int i = 0; i < limit; i++) begin
            dp  = arc_gap(qphi, phi_mem[i]);
            ds  = arc_gap(qpsi, psi_mem[i]);
            dw  = arc_gap(qomega, omega_mem[i]);
            sum = dp * dp + ds * ds + dw * dw;
            // strict compare keeps the lowest index on ties
            if (!best.found || sum < best.sq_dist) begin
                best.found   = 1'b1;
                best.index   = IDX_W'(i);
                best.phi     = phi_mem[i];
                best.psi     = psi_mem[i];
                best.omega   = omega_mem[i];
                best.sq_dist = sum;
            end
        end
        return best;
    endfunction

    task automatic log_error(string msg);
        errs++;
        if (errs <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string field, logic [DIST2_W-1:0] want,
                               logic [DIST2_W-1:0] got);
        if (got !== want)
            log_error($sformatf("%s mismatch: expected %0h, got %0h", field, want, got));
    endtask

    always @(posedge aclk) begin
        match_t got;
        match_t want;
        if (!aresetn) begin
            scan_count = '0;
            match_q.delete();
        end else begin
            if (cfg_we) scan_count = cfg_wdata;

            if (m_tvalid && m_tready) begin
                got.found   = m_tuser;
                got.index   = m_tdata[IDX_W-1:0];
                got.phi     = m_tdata[PHI_LSB +: ANGLE_W];
                got.psi     = m_tdata[PSI_LSB +: ANGLE_W];
                got.omega   = m_tdata[OMEGA_LSB +: ANGLE_W];
                got.sq_dist = m_tdata[DIST_LSB +: DIST2_W];
                if (match_q.size() == 0) begin
                    log_error($sformatf("result beat with no query pending: %0h", got));
                end else begin
                    want = match_q.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("best_index", want.index, got.index);
                    check_field("best_phi", want.phi, got.phi);
                    check_field("best_psi", want.psi, got.psi);
                    check_field("best_omega", want.omega, got.omega);
                    check_field("best_sq_distance", want.sq_dist, got.sq_dist);
                end
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    phi_mem[s_tdata[IDX_W-1:0]]   = s_tdata[PHI_LSB +: ANGLE_W];
                    psi_mem[s_tdata[IDX_W-1:0]]   = s_tdata[PSI_LSB +: ANGLE_W];
                    omega_mem[s_tdata[IDX_W-1:0]] = s_tdata[OMEGA_LSB +: ANGLE_W];
                end else begin
                    match_q.insert(match_q.size(),
                                   nearest_entry(s_tdata[PHI_LSB +: ANGLE_W],
                                                 s_tdata[PSI_LSB +: ANGLE_W],
                                                 s_tdata[OMEGA_LSB +: ANGLE_W]));
                end
            end
        end
        mismatch_count <= errs;
        pending_count  <= match_q.size();
    end

endmodule

FILE: test/tb_nearest_angle_triple_search.sv
// Testbench top for nearest_angle_triple_search: clock, reset, beat stimulus,
// entry_count writes and the verdict. Depends on nats_pkg, the block and nats_checker.

module tb_nearest_angle_triple_search;
    timeunit 1ns;
    timeprecision 1ps;

    import nats_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int ITEM_TARGET = 500;
    // longest quiet stretch; must well exceed a full 64-entry scan plus a
    // held result under receiver stalls
    localparam int QUIET_LIMIT = 4000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = OP_LOAD;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int mismatch_count;
    int pending_count;

    // idle odds in percent per cycle; start: sender lazy, receiver very lazy
    int send_idle_pct = 9;
    int recv_idle_pct = 50;
    int items_sent    = 0;

    // what the table holds, only used to aim queries near stored triples
    logic [ANGLE_W-1:0] shadow_phi   [ENTRIES];
    logic [ANGLE_W-1:0] shadow_psi   [ENTRIES];
    logic [ANGLE_W-1:0] shadow_omega [ENTRIES];

    always #5 aclk = ~aclk;

    nearest_angle_triple_search #(
        .MAX_ENTRIES(ENTRIES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    nats_checker #(
        .TABLE_DEPTH(ENTRIES)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: any accepted beat on either side resets the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // one input beat; an optional idle gap first, then hold until accepted
    task automatic send_item(logic op, logic [IDX_W-1:0] slot, logic [ANGLE_W-1:0] phi,
                             logic [ANGLE_W-1:0] psi, logic [ANGLE_W-1:0] omega);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({omega, psi, phi, slot});
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (op == OP_LOAD) begin
            shadow_phi[slot]   = phi;
            shadow_psi[slot]   = psi;
            shadow_omega[slot] = omega;
        end
        items_sent++;
        // idle schedule: swap the lazy sides after a third, then run flat out
        if (items_sent >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end else if (items_sent >= ITEM_TARGET / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 9;
        end
    endtask

    // drop valid, wait for every pending result, then let a trailing load settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // extremes of the angle range show up often
    function automatic logic [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // small offset, wraps across the half turn freely
    function automatic logic [ANGLE_W-1:0] nudge(logic [ANGLE_W-1:0] a);
        return a + ANGLE_W'($urandom_range(512)) - 16'd256;
    endfunction

    // first two phases pin the top of the range (saturated, then exact)
    function automatic logic [CFG_W-1:0] pick_count(int phase);
        if (phase == 0) return 7'd127;
        if (phase == 1) return CFG_W'(ENTRIES);
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'd127;
            2, 3, 4: return CFG_W'($urandom_range(1, 8));
            5:       return CFG_W'(ENTRIES);
            default: return CFG_W'($urandom_range(9, 127));
        endcase
    endfunction

    // random beat once the whole table is loaded
    task automatic random_item();
        int src;
        src = $urandom_range(ENTRIES - 1);
        case ($urandom_range(9))
            0, 1, 2: send_item(OP_LOAD, IDX_W'($urandom), pick_angle(), pick_angle(),
                               pick_angle());
            // duplicate of another slot, sets up ties
            3:       send_item(OP_LOAD, IDX_W'($urandom), shadow_phi[src], shadow_psi[src],
                               shadow_omega[src]);
            // query close to a stored triple
            4, 5, 6: send_item(OP_QUERY, IDX_W'($urandom), nudge(shadow_phi[src]),
                               nudge(shadow_psi[src]), nudge(shadow_omega[src]));
            default: send_item(OP_QUERY, IDX_W'($urandom), pick_angle(), pick_angle(),
                               pick_angle());
        endcase
    endtask

    initial begin : stimulus
        int phase;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table straight out of reset (entry_count resets to zero)
        send_item(OP_QUERY, 6'd63, 16'h8000, 16'h7FFF, 16'hFFFF);

        // small hand-built table: origin, both edges of the half turn, a tie pair
        send_item(OP_LOAD, 6'd0, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_LOAD, 6'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(OP_LOAD, 6'd2, 16'h8000, 16'h8000, 16'h8000);
        send_item(OP_LOAD, 6'd3, 16'hFFFF, 16'h0001, 16'h4000);
        send_item(OP_LOAD, 6'd4, 16'hFFFF, 16'h0001, 16'h4000);
        send_item(OP_LOAD, 6'd5, 16'h4000, 16'hC000, 16'h0000);
        send_item(OP_LOAD, 6'd63, 16'h1234, 16'hEDCB, 16'h8001);

        // explicit zero count: still an empty search
        drain();
        write_count(7'd0);
        send_item(OP_QUERY, 6'd0, 16'h0000, 16'h0000, 16'h0000);

        // one entry, exactly a half turn away on every angle: largest sum
        drain();
        write_count(7'd1);
        send_item(OP_QUERY, 6'd0, 16'h8000, 16'h8000, 16'h8000);

        drain();
        write_count(7'd6);
        send_item(OP_QUERY, 6'd0, 16'h8000, 16'h8000, 16'h8000);  // exact hit, slot 2
        send_item(OP_QUERY, 6'd9, 16'hFFFF, 16'h0001, 16'h4000);  // tie, lowest slot wins
        send_item(OP_QUERY, 6'd0, 16'h8000, 16'h7FFF, 16'h0001);  // wrap across +-pi
        send_item(OP_QUERY, 6'd0, 16'h0001, 16'h0001, 16'h0001);  // just past a half turn
        send_item(OP_QUERY, 6'd0, 16'h4000, 16'hC000, 16'h0000);  // exact hit, slot 5

        // fill every slot so any count is legal from here on
        drain();
        for (int i = 0; i < ENTRIES; i++)
            send_item(OP_LOAD, IDX_W'(i), pick_angle(), pick_angle(), pick_angle());

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            write_count(pick_count(phase));
            repeat ($urandom_range(8, 30)) random_item();
            phase++;
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
